FILE: design/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the spline arc-length lookup unit.
// ----------------------------------------------------------------------------
package sal_pkg;

	localparam int DIST_W  = 24;
	localparam int FRAC_W  = 17;
	localparam int SEG_W   = 6;
	localparam int COORD_W = 16;
	localparam int T_W     = 19;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [16:0] T_ONE = 17'd65536;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [T_W-1:0]     query_t;
	} req_t;

	typedef struct packed {
		logic [SEG_W-1:0]  segment_index;
		logic [FRAC_W-1:0] local_fraction;
		logic [1:0]        status;
	} rsp_t;

endpackage

FILE: design/sal_if.sv
// ----------------------------------------------------------------------------
// sal_if
// Valid/ready channel carrying one packed payload per beat.
// ----------------------------------------------------------------------------
interface sal_if #(
	parameter int W = 8
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/sal_divsqrt.sv
// ----------------------------------------------------------------------------
// sal_divsqrt
// Shared iterative unit: restoring divide or bit-pair square root,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module sal_divsqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_sqrt,
	input  logic [49:0] num,      // dividend or radicand
	input  logic [24:0] den,
	output logic        done,
	output logic [40:0] result
);
	import sal_pkg::*;

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        sqrt_q;
	logic [49:0] num_q;
	logic [50:0] rem_q;
	logic [40:0] res_q;
	logic [24:0] den_q;

	logic [50:0] rem_n;
	logic [50:0] trial;
	logic [49:0] num_n;
	logic [40:0] res_n;

	// one step of the selected recurrence
	always_comb begin
		num_n = num_q;
		res_n = res_q;
		if (sqrt_q) begin
			rem_n = {rem_q[48:0], num_q[49:48]};
			num_n = {num_q[47:0], 2'b00};
			trial = {8'd0, res_q, 2'b01};
		end else begin
			rem_n = {rem_q[49:0], num_q[49]};
			num_n = {num_q[48:0], 1'b0};
			trial = {26'd0, den_q};
		end
		if (rem_n >= trial) begin
			rem_n = rem_n - trial;
			res_n = {res_q[39:0], 1'b1};
		end else begin
			res_n = {res_q[39:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sqrt_q <= is_sqrt;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				res_q  <= '0;
				cnt_q  <= is_sqrt ? 6'd25 : 6'd50;
			end else if (busy_q) begin
				rem_q <= rem_n;
				num_q <= num_n;
				res_q <= res_n;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign result = res_q;
endmodule

FILE: design/spline_arc_length_lookup_unit.sv
// ----------------------------------------------------------------------------
// spline_arc_length_lookup_unit
// Cumulative arc-length table with append, clear and normalized lookup.
// ----------------------------------------------------------------------------
// One beat at a time. Append reads the last entry and runs a 25-step square
// root on the shared divide/root unit. Query reads the table one entry a cycle
// from the start until the target is passed (up to MAX_POINTS reads of the
// one-port table RAM), then runs a 50-step divide. The result register holds
// the output beat until it is taken; the next input beat is taken once the
// output beat has been taken. The table needs no clearing pass.
module spline_arc_length_lookup_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	sal_if.sink  in_ch,
	sal_if.source out_ch
);
	import sal_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_APP_RD, S_APP_SQ, S_APP_WAIT, S_Q_RDLAST, S_Q_SCAN,
		S_Q_CHK, S_Q_PREV, S_Q_DIV, S_Q_WAIT, S_OUT
	} state_t;

	state_t          state_q;
	req_t            req_q;
	rsp_t            rsp_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   idx_q;
	logic signed [COORD_W-1:0] lx_q, ly_q, lz_q;
	logic [DIST_W-1:0] mem [MAX_POINTS];
	logic [DIST_W-1:0] rd_q;
	logic [DIST_W-1:0] cur_q;
	logic [40:0]     target_q;
	logic [16:0]     tcl;
	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [DIST_W-1:0] mem_wd;
	logic            du_start, du_sqrt, du_done;
	logic [49:0]     du_num;
	logic [24:0]     du_den;
	logic [40:0]     du_res;
	logic [16:0]     adx, ady, adz;
	logic [33:0]     sqx, sqy, sqz;
	logic [49:0]     sumsq;
	logic [24:0]     dsum;
	logic [40:0]     base;
	logic [40:0]     tprod;

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = rsp_q;

	// table RAM, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		rd_q <= mem[mem_addr];
	end

	sal_divsqrt u_ds (
		.clk(clk), .arst_n(arst_n), .start(du_start), .is_sqrt(du_sqrt),
		.num(du_num), .den(du_den), .done(du_done), .result(du_res)
	);

	// clamp of t, absolute coordinate differences, squares, and the sums and products used by append and query
	always_comb begin
		logic signed [T_W-1:0] t;
		logic signed [16:0] dx, dy, dz;
		t = req_q.query_t;
		if (t < 0) tcl = '0;
		else if (t > $signed({2'b00, T_ONE})) tcl = T_ONE;
		else tcl = t[16:0];
		dx = 17'(req_q.point_x) - 17'(lx_q);
		dy = 17'(req_q.point_y) - 17'(ly_q);
		dz = 17'(req_q.point_z) - 17'(lz_q);
		adx = dx[16] ? 17'(-dx) : 17'(dx);
		ady = dy[16] ? 17'(-dy) : 17'(dy);
		adz = dz[16] ? 17'(-dz) : 17'(dz);
		sqx = adx * adx;
		sqy = ady * ady;
		sqz = adz * adz;
		sumsq = 50'(sqx) + 50'(sqy) + 50'(sqz);
		dsum = 25'(rd_q) + 25'(du_res);
		base = {1'b0, rd_q, 16'd0};
		tprod = tcl * rd_q;
	end

	// address / write / unit control
	always_comb begin
		mem_we = 1'b0;
		mem_wd = '0;
		mem_addr = idx_q;
		du_start = 1'b0;
		du_sqrt = 1'b0;
		du_num = '0;
		du_den = '0;
		case (state_q)
			S_APP_SQ: begin
				du_start = 1'b1;
				du_sqrt = 1'b1;
				du_num = sumsq;
			end
			S_APP_WAIT: begin
				// rd_q keeps the last entry until the root is done
				if (du_done) begin
					mem_addr = AW'(count_q);
					mem_we = 1'b1;
					mem_wd = (count_q == '0) ? '0 :
						(dsum > 25'(DIST_MAX)) ? DIST_MAX : dsum[DIST_W-1:0];
				end
			end
			S_Q_CHK: mem_addr = idx_q + AW'(1);
			S_Q_DIV: begin
				du_start = 1'b1;
				du_num = 50'(target_q - base);
				du_den = 25'(cur_q) - 25'(rd_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			lz_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					req_q <= in_ch.data;
					rsp_q <= '{default: '0};
					case (action_t'(in_ch.data[$bits(req_t)-1 -: 2]))
						ACT_CLEAR: begin
							count_q <= '0;
							lx_q <= '0;
							ly_q <= '0;
							lz_q <= '0;
							state_q <= S_OUT;
						end
						ACT_APPEND: begin
							idx_q <= AW'(count_q - CW'(1));
							state_q <= S_APP_RD;
						end
						ACT_QUERY: begin
							idx_q <= AW'(count_q - CW'(1));
							state_q <= S_Q_RDLAST;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_APP_RD: begin
					if (count_q >= CW'(MAX_POINTS)) begin
						rsp_q.status <= ST_FULL;
						state_q <= S_OUT;
					end else state_q <= S_APP_SQ;
				end
				S_APP_SQ: state_q <= S_APP_WAIT;
				S_APP_WAIT: if (du_done) begin
					count_q <= count_q + CW'(1);
					lx_q <= req_q.point_x;
					ly_q <= req_q.point_y;
					lz_q <= req_q.point_z;
					state_q <= S_OUT;
				end
				S_Q_RDLAST: begin
					if (count_q == '0) begin
						rsp_q.status <= ST_EMPTY;
						state_q <= S_OUT;
					end else begin
						idx_q <= '0;
						state_q <= S_Q_SCAN;
					end
				end
				S_Q_SCAN: begin
					// rd_q holds the last entry: form the target
					target_q <= tprod;
					state_q <= S_Q_CHK;
				end
				S_Q_CHK: begin
					// rd_q holds entry idx_q; the next entry is read meanwhile
					if ({1'b0, rd_q, 16'd0} >= target_q ||
						CW'(idx_q) == count_q - CW'(1)) begin
						if (idx_q == '0) state_q <= S_OUT;
						else begin
							cur_q <= rd_q;
							rsp_q.segment_index <= SEG_W'(idx_q - AW'(1));
							idx_q <= idx_q - AW'(1);
							state_q <= S_Q_PREV;
						end
					end else idx_q <= idx_q + AW'(1);
				end
				S_Q_PREV: state_q <= S_Q_DIV;
				S_Q_DIV: begin
					if (cur_q == rd_q || target_q < base) state_q <= S_OUT;
					else state_q <= S_Q_WAIT;
				end
				S_Q_WAIT: if (du_done) begin
					rsp_q.local_fraction <= (du_res > 41'(T_ONE)) ? T_ONE : du_res[16:0];
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
